// File: rtl/core/eoa_pkg.sv
// Shared types, constants and trig helpers for the odometry accumulator.
package eoa_pkg;

  // Field widths fixed by the interface
  localparam int COUNT_FIELD_W = 32;
  localparam int HEADING_W     = 16;
  localparam int TRIG_W        = 16;
  localparam int DEG_W         = 9;
  localparam int IPT_W         = 32;

  // Reset value of the distance-per-tick register (Q0.32 inches)
  localparam logic [IPT_W-1:0] IPT_RESET = 32'd6957348;

  // Angle constants in whole degrees
  localparam logic [DEG_W-1:0] DEG_90   = 9'd90;
  localparam logic [DEG_W-1:0] DEG_180  = 9'd180;
  localparam logic [DEG_W-1:0] DEG_270  = 9'd270;
  localparam logic [DEG_W-1:0] DEG_360  = 9'd360;
  // Multiple of 360 that lifts any 16-bit heading above zero
  localparam logic [17:0]      DEG_LIFT = 18'd33120;
  // ceil(2^25 / 360): exact quotient by 360 for any lifted heading
  localparam logic [16:0]      DEG_RECIP = 17'd93207;

  localparam int SINE_TABLE_ENTRIES = 91;
  localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);

  // Quarter-wave sine, Q1.15 magnitudes, one entry per degree
  localparam logic [TRIG_W-1:0] QUARTER_SINE [SINE_TABLE_ENTRIES] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32589, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // Request codes
  localparam logic REQ_UPDATE   = 1'b0;
  localparam logic REQ_ZERO_REF = 1'b1;

  // Datapath operations, one per sequencer step
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIFF,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_DIST,
    OP_MUL_X,
    OP_ACC_X,
    OP_MUL_Y,
    OP_ACC_Y,
    OP_ZERO_REF
  } op_t;

  typedef struct packed {
    logic load;   // capture the accepted input word
    op_t  op;     // datapath step this cycle
    logic push;   // move accumulators into the output register
  } cmd_t;

  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  // Reduce a signed heading into 0..359: lift it above zero, then take the
  // remainder by 360 through a reciprocal multiply
  function automatic logic [DEG_W-1:0] wrap_deg(logic signed [HEADING_W-1:0] h);
    logic [17:0] lifted;
    logic [33:0] prod;
    logic [7:0]  q;
    logic [16:0] rem;
    begin
      lifted   = {{2{h[HEADING_W-1]}}, h} + DEG_LIFT;
      prod     = {17'd0, lifted[16:0]} * {17'd0, DEG_RECIP};
      q        = prod[32:25];
      rem      = lifted[16:0] - ({9'd0, q} * {8'd0, DEG_360});
      wrap_deg = rem[DEG_W-1:0];
    end
  endfunction

  // Sine of a degree in 0..359 as magnitude and sign
  function automatic trig_t sine_of(logic [DEG_W-1:0] d);
    logic [DEG_W-1:0] idx;
    trig_t            t;
    begin
      t.neg = 1'b0;
      if (d <= DEG_90) begin
        idx = d;
      end else if (d <= DEG_180) begin
        idx = DEG_180 - d;
      end else if (d <= DEG_270) begin
        idx = d - DEG_180;
        t.neg = 1'b1;
      end else begin
        idx = DEG_360 - d;
        t.neg = 1'b1;
      end
      t.mag = QUARTER_SINE[idx[SINE_IDX_W-1:0]];
      sine_of = t;
    end
  endfunction

endpackage

// File: rtl/core/eoa_ctrl.sv
// Sequencer for the odometry accumulator: steps the datapath and owns the handshakes.
module eoa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output eoa_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_HI,
    S_MUL_LO,
    S_DIST,
    S_MUL_X,
    S_ACC_X,
    S_MUL_Y,
    S_ACC_Y,
    S_ZERO,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   push;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = (state_r == S_IDLE) && in_valid;
  assign push      = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Decode the step for the datapath
  always_comb begin
    cmd.load = accept;
    cmd.push = push;
    case (state_r)
      S_DIFF:   cmd.op = eoa_pkg::OP_DIFF;
      S_MUL_HI: cmd.op = eoa_pkg::OP_MUL_HI;
      S_MUL_LO: cmd.op = eoa_pkg::OP_MUL_LO;
      S_DIST:   cmd.op = eoa_pkg::OP_DIST;
      S_MUL_X:  cmd.op = eoa_pkg::OP_MUL_X;
      S_ACC_X:  cmd.op = eoa_pkg::OP_ACC_X;
      S_MUL_Y:  cmd.op = eoa_pkg::OP_MUL_Y;
      S_ACC_Y:  cmd.op = eoa_pkg::OP_ACC_Y;
      S_ZERO:   cmd.op = eoa_pkg::OP_ZERO_REF;
      default:  cmd.op = eoa_pkg::OP_IDLE;
    endcase
  end

  // Advance through the steps
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_type == eoa_pkg::REQ_ZERO_REF) ? S_ZERO : S_DIFF;
        end
      end
      S_DIFF:   state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_MUL_LO;
      S_MUL_LO: state_nxt = S_DIST;
      S_DIST:   state_nxt = S_MUL_X;
      S_MUL_X:  state_nxt = S_ACC_X;
      S_ACC_X:  state_nxt = S_MUL_Y;
      S_MUL_Y:  state_nxt = S_ACC_Y;
      S_ACC_Y:  state_nxt = S_DONE;
      S_ZERO:   state_nxt = S_DONE;
      S_DONE: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Track the output word: set on push, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/eoa_datapath.sv
// Datapath for the odometry accumulator: count deltas, shared multiplier, saturating sums.
module eoa_datapath #(
  parameter int COUNT_BITS    = 32,
  parameter int POSITION_BITS = 48
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  eoa_pkg::cmd_t                              cmd,
  input  logic                                       cfg_wr_en,
  input  logic [eoa_pkg::IPT_W-1:0]                  cfg_wr_data,
  input  logic signed [eoa_pkg::COUNT_FIELD_W-1:0]   in_left_count,
  input  logic signed [eoa_pkg::COUNT_FIELD_W-1:0]   in_right_count,
  input  logic signed [eoa_pkg::HEADING_W-1:0]       in_heading_deg,
  output logic signed [POSITION_BITS-1:0]            out_x_pos,
  output logic signed [POSITION_BITS-1:0]            out_y_pos
);

  localparam int MW = COUNT_BITS + 1;          // count-change magnitude
  localparam int DW = COUNT_BITS + 16;         // distance in Q.16
  localparam int PW = DW + eoa_pkg::TRIG_W;    // multiplier product
  localparam int SW = ((POSITION_BITS > DW + 1) ? POSITION_BITS : DW + 1) + 1;
  localparam int TW = eoa_pkg::TRIG_W;
  localparam int GW = eoa_pkg::DEG_W;

  localparam logic signed [SW-1:0] P_MAX =
    {{(SW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] P_MIN =
    {{(SW-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

  logic [eoa_pkg::IPT_W-1:0]       ipt_r;
  logic signed [COUNT_BITS-1:0]    left_r, right_r, lref_r, rref_r;
  logic signed [eoa_pkg::HEADING_W-1:0] head_r;
  logic [MW-1:0]                   m_r;
  logic                            neg_r;
  logic [GW-1:0]                   deg_r;
  logic [TW-1:0]                   sin_mag_r, cos_mag_r;
  logic                            x_neg_r, y_neg_r;
  logic [PW-1:0]                   prod_r;
  logic [DW:0]                     hi_r;
  logic [DW-1:0]                   dist_r;
  logic signed [POSITION_BITS-1:0] x_r, y_r, out_x_r, out_y_r;

  logic signed [COUNT_BITS+1:0]    l_ext, r_ext, lr_ext, rr_ext, diff_s, diff_neg;
  logic [GW:0]                     d90_sum;
  logic [GW-1:0]                   d90;
  eoa_pkg::trig_t                  sin_t, cos_t;
  logic [DW-1:0]                   mul_a;
  logic [TW-1:0]                   mul_b;
  logic [PW-1:0]                   mul_p;
  logic [DW+1:0]                   dist_sum;
  logic [DW:0]                     step_mag;
  logic                            step_neg;
  logic signed [SW-1:0]            step_s, acc_s, sum_s;
  logic signed [POSITION_BITS-1:0] acc_sel, sat_v;

  assign out_x_pos = out_x_r;
  assign out_y_pos = out_y_r;

  // Exact signed count change, left side negated
  assign l_ext    = {{2{left_r[COUNT_BITS-1]}}, left_r};
  assign r_ext    = {{2{right_r[COUNT_BITS-1]}}, right_r};
  assign lr_ext   = {{2{lref_r[COUNT_BITS-1]}}, lref_r};
  assign rr_ext   = {{2{rref_r[COUNT_BITS-1]}}, rref_r};
  assign diff_s   = (r_ext - rr_ext) - (l_ext - lr_ext);
  assign diff_neg = -diff_s;

  // Heading plus a quarter turn for the cosine
  assign d90_sum = {1'b0, deg_r} + {1'b0, eoa_pkg::DEG_90};
  assign d90     = (d90_sum >= {1'b0, eoa_pkg::DEG_360}) ?
                   GW'(d90_sum - {1'b0, eoa_pkg::DEG_360}) : d90_sum[GW-1:0];
  assign sin_t   = eoa_pkg::sine_of(deg_r);
  assign cos_t   = eoa_pkg::sine_of(d90);

  // Shared multiplier operand select
  always_comb begin
    case (cmd.op)
      eoa_pkg::OP_MUL_HI: begin
        mul_a = {{(DW-MW){1'b0}}, m_r};
        mul_b = ipt_r[eoa_pkg::IPT_W-1:16];
      end
      eoa_pkg::OP_MUL_LO: begin
        mul_a = {{(DW-MW){1'b0}}, m_r};
        mul_b = ipt_r[15:0];
      end
      eoa_pkg::OP_MUL_X: begin
        mul_a = dist_r;
        mul_b = sin_mag_r;
      end
      eoa_pkg::OP_MUL_Y: begin
        mul_a = dist_r;
        mul_b = cos_mag_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Distance = (m*k_hi + (m*k_lo >> 16)) >> 1
  assign dist_sum = {1'b0, hi_r} + {2'b00, prod_r[PW-1:16]};

  // Signed trig step and saturating add into the chosen axis
  assign step_mag = prod_r[PW-1:15];
  assign step_neg = (cmd.op == eoa_pkg::OP_ACC_Y) ? y_neg_r : x_neg_r;
  assign acc_sel  = (cmd.op == eoa_pkg::OP_ACC_Y) ? y_r : x_r;
  assign step_s   = step_neg ? -$signed({{(SW-DW-1){1'b0}}, step_mag})
                             :  $signed({{(SW-DW-1){1'b0}}, step_mag});
  assign acc_s    = {{(SW-POSITION_BITS){acc_sel[POSITION_BITS-1]}}, acc_sel};
  assign sum_s    = acc_s + step_s;

  always_comb begin
    if (sum_s > P_MAX) begin
      sat_v = P_MAX[POSITION_BITS-1:0];
    end else if (sum_s < P_MIN) begin
      sat_v = P_MIN[POSITION_BITS-1:0];
    end else begin
      sat_v = sum_s[POSITION_BITS-1:0];
    end
  end

  // Configuration and control-visible state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipt_r  <= eoa_pkg::IPT_RESET;
      lref_r <= '0;
      rref_r <= '0;
      x_r    <= '0;
      y_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        ipt_r <= cfg_wr_data;
      end
      case (cmd.op)
        eoa_pkg::OP_DIFF: begin
          lref_r <= left_r;
          rref_r <= right_r;
        end
        eoa_pkg::OP_ZERO_REF: begin
          lref_r <= '0;
          rref_r <= '0;
        end
        eoa_pkg::OP_ACC_X: x_r <= sat_v;
        eoa_pkg::OP_ACC_Y: y_r <= sat_v;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= in_left_count[COUNT_BITS-1:0];
      right_r <= in_right_count[COUNT_BITS-1:0];
      head_r  <= in_heading_deg;
    end
    if (cmd.push) begin
      out_x_r <= x_r;
      out_y_r <= y_r;
    end
    case (cmd.op)
      eoa_pkg::OP_DIFF: begin
        neg_r <= diff_s[COUNT_BITS+1];
        m_r   <= diff_s[COUNT_BITS+1] ? diff_neg[MW-1:0] : diff_s[MW-1:0];
        deg_r <= eoa_pkg::wrap_deg(head_r);
      end
      eoa_pkg::OP_MUL_HI: begin
        prod_r    <= mul_p;
        sin_mag_r <= sin_t.mag;
        cos_mag_r <= cos_t.mag;
        x_neg_r   <= neg_r ^ sin_t.neg;
        y_neg_r   <= neg_r ^ cos_t.neg;
      end
      eoa_pkg::OP_MUL_LO: begin
        hi_r   <= prod_r[DW:0];
        prod_r <= mul_p;
      end
      eoa_pkg::OP_DIST:  dist_r <= dist_sum[DW:1];
      eoa_pkg::OP_MUL_X: prod_r <= mul_p;
      eoa_pkg::OP_MUL_Y: prod_r <= mul_p;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/encoder_odometry_accumulator.sv
// Top level of the differential-drive odometry accumulator.
//
// Input channel (in_valid / in_stall): one word per update. in_req_type 0
// takes new left and right encoder counts and a heading in whole degrees
// and moves x and y by the averaged, scaled distance times sin and cos.
// in_req_type 1 zeroes the stored reference counts and keeps the position.
// Output channel (out_valid / out_stall): one word per input word carrying
// x_pos and y_pos, signed Q32.16 inches, saturating at the position width.
// cfg_wr_en / cfg_wr_data load inches_per_tick (Q0.32); write only when idle.
// Sequence: an update word steps through difference, scale high and low,
// distance, x product and sum, y product and sum, then done; a reference-zero
// word steps through zero, then done. out_valid rises as the sequencer leaves
// done. The steps follow from one 48x16 multiplier that is used four times
// per update (two halves of the scale, then sin, cos). The output is a
// register: the next word is accepted while a result waits, and the
// sequencer holds at its last step while an earlier result is still stalled.
// Reset (rst_n low, synchronous) clears position, references and the
// output valid, and restores inches_per_tick to its default.
module encoder_odometry_accumulator #(
  parameter int COUNT_BITS    = 32,
  parameter int POSITION_BITS = 48
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_wr_en,
  input  logic [eoa_pkg::IPT_W-1:0]                cfg_wr_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_req_type,
  input  logic signed [eoa_pkg::COUNT_FIELD_W-1:0] in_left_count,
  input  logic signed [eoa_pkg::COUNT_FIELD_W-1:0] in_right_count,
  input  logic signed [eoa_pkg::HEADING_W-1:0]     in_heading_deg,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [POSITION_BITS-1:0]          out_x_pos,
  output logic signed [POSITION_BITS-1:0]          out_y_pos
);

  eoa_pkg::cmd_t cmd;

  eoa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  eoa_datapath #(
    .COUNT_BITS    (COUNT_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_heading_deg (in_heading_deg),
    .out_x_pos      (out_x_pos),
    .out_y_pos      (out_y_pos)
  );

  // An accepted word keeps the input side busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again right after an accept");

  // A new result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result pushed while sequencer still busy");

  // The datapath never loads inputs while it is stepping
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (cmd.op == eoa_pkg::OP_IDLE) && !cmd.push)
    else $error("input load overlaps a datapath step");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the odometry accumulator: random and directed words against a predictor.
module testbench;

  localparam int     POS_W  = 48;
  localparam longint POS_HI = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_LO = -POS_HI - 1;

  // Quarter-wave sine magnitudes, Q1.15, one per degree
  localparam bit [15:0] SINE_Q15 [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32589, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pose_t;

  // Pose predictor plus the queue of poses still owed by the block
  class odometry_scoreboard;
    bit [eoa_pkg::IPT_W-1:0] ipt;
    longint                  ref_left;
    longint                  ref_right;
    longint                  x_acc;
    longint                  y_acc;
    pose_t                   pose_q[$];
    int                      mismatches;

    function new();
      ipt        = eoa_pkg::IPT_RESET;
      ref_left   = 0;
      ref_right  = 0;
      x_acc      = 0;
      y_acc      = 0;
      mismatches = 0;
    endfunction

    function void set_ipt(bit [eoa_pkg::IPT_W-1:0] v);
      ipt = v;
    endfunction

    function int pending();
      return pose_q.size();
    endfunction

    // Sine of a degree in 0..359 as magnitude and sign
    function bit [15:0] sine_mag(int d, output bit neg);
      neg = 1'b0;
      if (d <= 90) return SINE_Q15[d];
      if (d <= 180) return SINE_Q15[180 - d];
      neg = 1'b1;
      if (d <= 270) return SINE_Q15[d - 180];
      return SINE_Q15[360 - d];
    endfunction

    function longint trig_step(bit [63:0] dist_mag, bit dist_neg, int d);
      bit        tneg;
      bit [15:0] trig;
      bit [63:0] mag;
      trig = sine_mag(d, tneg);
      mag  = (dist_mag * {48'd0, trig}) >> 15;
      return (dist_neg != tneg) ? -longint'(mag) : longint'(mag);
    endfunction

    function longint sat_add(longint acc, longint step);
      if (step > 0 && acc > POS_HI - step) return POS_HI;
      if (step < 0 && acc < POS_LO - step) return POS_LO;
      return acc + step;
    endfunction

    // Predict the pose after one accepted word and queue it
    function void note_word(logic req, logic signed [eoa_pkg::COUNT_FIELD_W-1:0] lc,
                            logic signed [eoa_pkg::COUNT_FIELD_W-1:0] rc,
                            logic signed [eoa_pkg::HEADING_W-1:0] hd);
      longint    left;
      longint    right;
      longint    s;
      bit        neg;
      bit [63:0] m;
      bit [63:0] hi;
      bit [63:0] lo;
      bit [63:0] dist_q16;
      int        h;
      pose_t     p;
      if (req == eoa_pkg::REQ_ZERO_REF) begin
        ref_left  = 0;
        ref_right = 0;
      end else begin
        left     = lc;
        right    = rc;
        s        = (right - ref_right) - (left - ref_left);
        neg      = s < 0;
        m        = neg ? 64'(-s) : 64'(s);
        hi       = m * {48'd0, ipt[31:16]};
        lo       = m * {48'd0, ipt[15:0]};
        dist_q16 = (hi + (lo >> 16)) >> 1;
        h        = hd;
        h        = h % 360;
        if (h < 0) h += 360;
        x_acc     = sat_add(x_acc, trig_step(dist_q16, neg, h));
        y_acc     = sat_add(y_acc, trig_step(dist_q16, neg, (h + 90) % 360));
        ref_left  = left;
        ref_right = right;
      end
      p.x = x_acc[POS_W-1:0];
      p.y = y_acc[POS_W-1:0];
      pose_q.push_back(p);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compare one delivered pose with the oldest prediction
    task check_result(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      pose_t p;
      if (pose_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pose x=%h y=%h", x, y));
      end else begin
        p = pose_q.pop_front();
        if (x !== p.x) report_mismatch($sformatf("x_pos %h, predicted %h", x, p.x));
        if (y !== p.y) report_mismatch($sformatf("y_pos %h, predicted %h", y, p.y));
      end
    endtask
  endclass

  logic                                     clk = 1'b0;
  logic                                     rst_n = 1'b0;
  logic                                     cfg_wr_en = 1'b0;
  logic [eoa_pkg::IPT_W-1:0]                cfg_wr_data = '0;
  logic                                     in_valid = 1'b0;
  logic                                     in_stall;
  logic                                     in_req_type = eoa_pkg::REQ_UPDATE;
  logic signed [eoa_pkg::COUNT_FIELD_W-1:0] in_left_count = '0;
  logic signed [eoa_pkg::COUNT_FIELD_W-1:0] in_right_count = '0;
  logic signed [eoa_pkg::HEADING_W-1:0]     in_heading_deg = '0;
  logic                                     out_valid;
  logic                                     out_stall = 1'b0;
  logic signed [POS_W-1:0]                  out_x_pos;
  logic signed [POS_W-1:0]                  out_y_pos;

  odometry_scoreboard sb = new();

  // Traffic shaping: quiet and idle_div shared by sender and receiver
  int quiet     = 0;
  int idle_div  = 6;
  int long_hold = 0;
  int stall_run = 0;

  // Encoder counts that the sender walks forward in small steps
  int cur_left  = 0;
  int cur_right = 0;

  encoder_odometry_accumulator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_left_count  (in_left_count),
    .in_right_count (in_right_count),
    .in_heading_deg (in_heading_deg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_pos      (out_x_pos),
    .out_y_pos      (out_y_pos)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one word, with an optional idle burst ahead of it
  task send_word(logic req, logic signed [eoa_pkg::COUNT_FIELD_W-1:0] l,
                 logic signed [eoa_pkg::COUNT_FIELD_W-1:0] r,
                 logic signed [eoa_pkg::HEADING_W-1:0] h);
    int gap;
    if (quiet == 0 && $urandom_range(0, idle_div - 1) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       = 1'b1;
    in_req_type    = req;
    in_left_count  = l;
    in_right_count = r;
    in_heading_deg = h;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(req, l, r, h);
  endtask

  // Drop valid and wait until every predicted pose has come back
  task drain_block();
    @(negedge clk) in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task write_ipt(logic [eoa_pkg::IPT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk) cfg_wr_en = 1'b0;
    sb.set_ipt(v);
  endtask

  // Mostly small forward motion, some full-range and extreme counts
  task send_random();
    logic                                     req;
    logic signed [eoa_pkg::COUNT_FIELD_W-1:0] l;
    logic signed [eoa_pkg::COUNT_FIELD_W-1:0] r;
    logic signed [eoa_pkg::HEADING_W-1:0]     h;
    int                                       pick;
    req  = ($urandom_range(0, 11) == 0) ? eoa_pkg::REQ_ZERO_REF : eoa_pkg::REQ_UPDATE;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      cur_left  = cur_left - (int'($urandom_range(0, 1600)) - 700);
      cur_right = cur_right + (int'($urandom_range(0, 1600)) - 700);
      l = cur_left;
      r = cur_right;
    end else if (pick < 9) begin
      l = $urandom;
      r = $urandom;
      cur_left  = l;
      cur_right = r;
    end else begin
      l = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      r = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      cur_left  = l;
      cur_right = r;
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) h = 16'($urandom_range(0, 359));
    else if (pick < 8) h = 16'($urandom);
    else h = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    // encoders restart from zero along with the stored references
    if (req == eoa_pkg::REQ_ZERO_REF) begin
      cur_left  = 0;
      cur_right = 0;
    end
    send_word(req, l, r, h);
  endtask

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall = 1'b1;
        long_hold--;
      end else if (stall_run > 0) begin
        out_stall = 1'b1;
        stall_run--;
      end else if (quiet == 0 && $urandom_range(0, idle_div - 1) == 0) begin
        out_stall = 1'b1;
        stall_run = $urandom_range(1, 12) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Check every delivered pose
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_x_pos, out_y_pos);
    end
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int ph;
    int i;
    logic [eoa_pkg::IPT_W-1:0] ipt_v;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Headings on every quadrant boundary and wrap, default scale
    send_word(eoa_pkg::REQ_UPDATE, 0, 0, 0);
    send_word(eoa_pkg::REQ_UPDATE, -1000, 1000, 0);
    send_word(eoa_pkg::REQ_UPDATE, -2000, 2000, 90);
    send_word(eoa_pkg::REQ_UPDATE, -3000, 3000, 180);
    send_word(eoa_pkg::REQ_UPDATE, -4000, 4000, 270);
    send_word(eoa_pkg::REQ_UPDATE, -5000, 5000, 359);
    send_word(eoa_pkg::REQ_UPDATE, -6000, 6000, -1);
    send_word(eoa_pkg::REQ_UPDATE, -7000, 7000, 16'sh7fff);
    send_word(eoa_pkg::REQ_UPDATE, -8000, 8000, 16'sh8000);
    send_word(eoa_pkg::REQ_UPDATE, -9000, 9000, 450);
    send_word(eoa_pkg::REQ_UPDATE, -8000, 8000, -90);
    // Zero references, then an update measured from zero
    send_word(eoa_pkg::REQ_ZERO_REF, 32'sh12345678, -5, 45);
    send_word(eoa_pkg::REQ_UPDATE, -500, 700, 45);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh80000000, 32'sh7fffffff, 135);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh7fffffff, 32'sh80000000, 225);

    // Full scale: drive both axes into saturation and back off
    drain_block();
    write_ipt(32'hffffffff);
    send_word(eoa_pkg::REQ_ZERO_REF, 0, 0, 0);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh80000000, 32'sh7fffffff, 90);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh7fffffff, 32'sh80000000, 270);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh80000000, 32'sh7fffffff, 0);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh7fffffff, 32'sh80000000, 0);
    send_word(eoa_pkg::REQ_UPDATE, 32'sh80000000, 32'sh7fffffff, 180);
    send_word(eoa_pkg::REQ_ZERO_REF, -1, -1, 16'sh8000);
    send_word(eoa_pkg::REQ_UPDATE, -1, 1, 90);
    send_word(eoa_pkg::REQ_UPDATE, 1, -1, 90);

    // Random phases, each under its own scale setting
    for (ph = 0; ph < 6; ph++) begin
      drain_block();
      case (ph)
        0: ipt_v = eoa_pkg::IPT_RESET;
        1: ipt_v = $urandom;
        2: ipt_v = 32'hffffffff;
        3: ipt_v = 32'd0;
        4: ipt_v = $urandom_range(1, 32'h00100000);
        default: ipt_v = eoa_pkg::IPT_RESET;
      endcase
      write_ipt(ipt_v);
      cur_left  = 0;
      cur_right = 0;
      send_word(eoa_pkg::REQ_ZERO_REF, 0, 0, 0);
      idle_div = (ph % 2 == 0) ? 6 : 24;
      quiet    = int'(ph == 5);
      for (i = 0; i < 300; i++) begin
        // hold the receiver off long enough to back up the input
        if (ph == 1 && i == 40) long_hold = 400;
        // pause the sender until the block has delivered everything
        if (ph == 2 && i == 150) begin
          @(negedge clk) in_valid = 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_random();
      end
    end

    drain_block();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
